FILE: rtl/bezier_patch_point_evaluator_top_macros.svh
// Assertion helpers for the patch evaluator checker.
`ifndef BEZIER_PATCH_POINT_EVALUATOR_TOP_MACROS_SVH
`define BEZIER_PATCH_POINT_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/bpe_pkg.sv
package bpe_pkg;

	localparam int COORD_W = 32;
	localparam int W_W     = 31;
	localparam int PAR_W   = 17;
	localparam int CFG_W   = 5;
	localparam int CNT_W   = 6;
	localparam int OFS_W   = 4;

	localparam logic [PAR_W-1:0] PAR_ONE = 17'd65536;
	localparam logic [W_W-1:0]   W_ONE   = 31'h4000_0000;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_GRID_ROWS  = 2'd0;
	localparam cfg_idx_t CFG_GRID_COLS  = 2'd1;
	localparam cfg_idx_t CFG_GROUP_ROWS = 2'd2;
	localparam cfg_idx_t CFG_GROUP_COLS = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef struct packed {
		logic                      op;
		logic [7:0]                point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [PAR_W-1:0]          param_u;
		logic [PAR_W-1:0]          param_v;
		logic [OFS_W-1:0]          row_offset;
		logic [OFS_W-1:0]          col_offset;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] surf_x;
		logic signed [COORD_W-1:0] surf_y;
		logic signed [COORD_W-1:0] surf_z;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic start;
		logic mod_step;
		logic bern_step;
		logic acc_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic bern_skip;
		logic bern_last;
		logic acc_last;
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/bpe_ctrl.sv
module bpe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_op,
	input  bpe_pkg::status_t st,
	output logic             in_ready,
	output bpe_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_BERN,
		S_ACC,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   accept;

	assign in_ready = in_ready_q;
	assign accept   = in_valid && in_ready_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && accept && (in_op == bpe_pkg::OP_LOAD);
		cmd.start     = (state_q == S_IDLE) && accept && (in_op == bpe_pkg::OP_EVAL);
		cmd.mod_step  = (state_q == S_MOD);
		cmd.bern_step = (state_q == S_BERN);
		cmd.acc_step  = (state_q == S_ACC);
		cmd.finish    = (state_q == S_FIN) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					in_ready_q <= 1'b1;
					if (accept && in_op == bpe_pkg::OP_EVAL) begin
						state_q    <= S_MOD;
						in_ready_q <= 1'b0;
					end
				end
				S_MOD: begin
					if (st.mod_done) begin
						state_q <= st.bern_skip ? S_ACC : S_BERN;
					end
				end
				S_BERN: begin
					if (st.bern_last) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (st.acc_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!st.pipe_busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (st.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/bpe_dp.sv
module bpe_dp #(
	parameter int MAX_GRID_DIM = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpe_pkg::in_word_t             in_data,
	input  logic                          cfg_valid,
	input  bpe_pkg::cfg_idx_t             cfg_index,
	input  logic [bpe_pkg::CFG_W-1:0]     cfg_data,
	input  bpe_pkg::cmd_t                 cmd,
	output bpe_pkg::status_t              st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bpe_pkg::out_word_t            out_data
);

	localparam int IDX_W  = $clog2(MAX_GRID_DIM);
	localparam int DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW     = bpe_pkg::COORD_W;
	localparam int WW     = bpe_pkg::W_W;
	localparam int CNW    = bpe_pkg::CNT_W;
	localparam int BP_W   = bpe_pkg::PAR_W + WW + 1;
	localparam int PW_W   = 2 * WW;
	localparam int PR_W   = 2 * CW;
	localparam int ACC_W  = CW + WW + 2 * IDX_W + 2;

	localparam logic [BP_W-1:0]         BP_RND  = BP_W'(32768);
	localparam logic [PW_W-1:0]         PW_RND  = PW_W'(64'd536870912);
	localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'sd536870912);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);
	localparam logic [CNW-1:0]          DIM_MAX = CNW'(MAX_GRID_DIM);

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} ent_t;

	function automatic logic signed [CW-1:0] sat_fn(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		r = (a + ACC_RND) >>> 30;
		if (r > SAT_MAX) begin
			return SAT_MAX[CW-1:0];
		end else if (r < SAT_MIN) begin
			return SAT_MIN[CW-1:0];
		end
		return r[CW-1:0];
	endfunction

	logic [bpe_pkg::CFG_W-1:0] grid_rows_q, grid_cols_q, group_rows_q, group_cols_q;

	ent_t             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic [CNW-1:0] eff_r, eff_c, eff_gr, eff_gc, g_r, g_c;
	logic [CNW-1:0] r_q, c_q, gr_q, gc_q;
	logic [CNW-1:0] dgu, dgv, kmax;
	logic [bpe_pkg::PAR_W-1:0] tu_q, su_q, tv_q, sv_q, tu_in, tv_in;
	logic [bpe_pkg::OFS_W-1:0] rmod_q, cmod_q;

	logic [WW-1:0]    wu_q [MAX_GRID_DIM];
	logic [WW-1:0]    wv_q [MAX_GRID_DIM];
	logic [WW-1:0]    prevu_q, prevv_q, wu_i, wv_i;
	logic [BP_W-1:0]  nu_c, nv_c;
	logic [IDX_W-1:0] k_q, i_q;

	logic [IDX_W-1:0]  row_q, col_q, col0_q, n_q, m_q;
	logic [ADDR_W-1:0] addr_c;
	logic [PW_W-1:0]   pw_c;
	logic              col_wrap, row_wrap, n_last, m_last;

	ent_t                     rd_s1;
	logic                     vld_s1, v_s1, v_s2;
	logic [WW-1:0]            w_s1;
	logic signed [PR_W-1:0]   px_s2, py_s2, pz_s2;
	logic signed [ACC_W-1:0]  acc_x_q, acc_y_q, acc_z_q;
	ent_t                     crd;

	logic               out_valid_q;
	bpe_pkg::out_word_t out_q;

	always_comb begin
		eff_r = (grid_rows_q == '0) ? CNW'(1) :
			(CNW'(grid_rows_q) > DIM_MAX) ? DIM_MAX : CNW'(grid_rows_q);
		eff_c = (grid_cols_q == '0) ? CNW'(1) :
			(CNW'(grid_cols_q) > DIM_MAX) ? DIM_MAX : CNW'(grid_cols_q);
		g_r    = CNW'(group_rows_q);
		g_c    = CNW'(group_cols_q);
		eff_gr = (g_r > CNW'(1) && g_r <= eff_r) ? g_r : eff_r;
		eff_gc = (g_c > CNW'(1) && g_c <= eff_c) ? g_c : eff_c;
		tu_in  = (in_data.param_u > bpe_pkg::PAR_ONE) ? bpe_pkg::PAR_ONE : in_data.param_u;
		tv_in  = (in_data.param_v > bpe_pkg::PAR_ONE) ? bpe_pkg::PAR_ONE : in_data.param_v;
	end

	assign dgu  = gc_q - CNW'(1);
	assign dgv  = gr_q - CNW'(1);
	assign kmax = (dgu > dgv) ? dgu : dgv;

	assign wu_i = wu_q[i_q];
	assign wv_i = wv_q[i_q];
	assign nu_c = BP_W'(su_q) * BP_W'(wu_i) + BP_W'(tu_q) * BP_W'(prevu_q) + BP_RND;
	assign nv_c = BP_W'(sv_q) * BP_W'(wv_i) + BP_W'(tv_q) * BP_W'(prevv_q) + BP_RND;

	assign addr_c   = ADDR_W'(row_q) * ADDR_W'(c_q) + ADDR_W'(col_q);
	assign pw_c     = PW_W'(wu_q[n_q]) * PW_W'(wv_q[m_q]) + PW_RND;
	assign col_wrap = (CNW'(col_q) + CNW'(1)) == c_q;
	assign row_wrap = (CNW'(row_q) + CNW'(1)) == r_q;
	assign n_last   = (CNW'(n_q) + CNW'(1)) == gc_q;
	assign m_last   = (CNW'(m_q) + CNW'(1)) == gr_q;
	assign crd      = vld_s1 ? rd_s1 : '0;

	always_comb begin
		st           = '0;
		st.mod_done  = (CNW'(rmod_q) < r_q) && (CNW'(cmod_q) < c_q);
		st.bern_skip = (kmax == '0);
		st.bern_last = (CNW'(k_q) == kmax) && (i_q == k_q);
		st.acc_last  = n_last && m_last;
		st.pipe_busy = v_s1 || v_s2;
		st.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q  <= bpe_pkg::CFG_W'(4);
			grid_cols_q  <= bpe_pkg::CFG_W'(4);
			group_rows_q <= bpe_pkg::CFG_W'(4);
			group_cols_q <= bpe_pkg::CFG_W'(4);
			vld_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bpe_pkg::CFG_GRID_ROWS:  grid_rows_q  <= cfg_data;
					bpe_pkg::CFG_GRID_COLS:  grid_cols_q  <= cfg_data;
					bpe_pkg::CFG_GROUP_ROWS: group_rows_q <= cfg_data;
					bpe_pkg::CFG_GROUP_COLS: group_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load && (32'(in_data.point_index) < DEPTH)) begin
				vld_q[ADDR_W'(in_data.point_index)] <= 1'b1;
			end
			v_s1 <= cmd.acc_step;
			v_s2 <= v_s1;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (32'(in_data.point_index) < DEPTH)) begin
			mem[ADDR_W'(in_data.point_index)] <= {in_data.point_x, in_data.point_y,
				in_data.point_z};
		end
		if (cmd.acc_step) begin
			rd_s1  <= mem[addr_c];
			vld_s1 <= vld_q[addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q    <= eff_r;
			c_q    <= eff_c;
			gr_q   <= eff_gr;
			gc_q   <= eff_gc;
			tu_q   <= tu_in;
			su_q   <= bpe_pkg::PAR_ONE - tu_in;
			tv_q   <= tv_in;
			sv_q   <= bpe_pkg::PAR_ONE - tv_in;
			rmod_q <= in_data.row_offset;
			cmod_q <= in_data.col_offset;
			for (int j = 0; j < MAX_GRID_DIM; j++) begin
				wu_q[j] <= '0;
				wv_q[j] <= '0;
			end
			wu_q[0] <= bpe_pkg::W_ONE;
			wv_q[0] <= bpe_pkg::W_ONE;
			k_q     <= IDX_W'(1);
			i_q     <= '0;
			prevu_q <= '0;
			prevv_q <= '0;
			n_q     <= '0;
			m_q     <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end
		if (cmd.mod_step) begin
			if (CNW'(rmod_q) >= r_q) begin
				rmod_q <= rmod_q - bpe_pkg::OFS_W'(r_q);
			end
			if (CNW'(cmod_q) >= c_q) begin
				cmod_q <= cmod_q - bpe_pkg::OFS_W'(c_q);
			end
			row_q  <= IDX_W'(rmod_q);
			col_q  <= IDX_W'(cmod_q);
			col0_q <= IDX_W'(cmod_q);
		end
		if (cmd.bern_step) begin
			if (CNW'(k_q) <= dgu) begin
				wu_q[i_q] <= WW'(nu_c >> 16);
				prevu_q   <= wu_i;
			end
			if (CNW'(k_q) <= dgv) begin
				wv_q[i_q] <= WW'(nv_c >> 16);
				prevv_q   <= wv_i;
			end
			if (i_q == k_q) begin
				i_q     <= '0;
				k_q     <= k_q + IDX_W'(1);
				prevu_q <= '0;
				prevv_q <= '0;
			end else begin
				i_q <= i_q + IDX_W'(1);
			end
		end
		if (cmd.acc_step) begin
			w_s1 <= WW'(pw_c >> 30);
			if (n_last) begin
				n_q   <= '0;
				m_q   <= m_q + IDX_W'(1);
				col_q <= col0_q;
				row_q <= row_wrap ? '0 : row_q + IDX_W'(1);
			end else begin
				n_q   <= n_q + IDX_W'(1);
				col_q <= col_wrap ? '0 : col_q + IDX_W'(1);
			end
		end
		if (v_s1) begin
			px_s2 <= crd.x * $signed({1'b0, w_s1});
			py_s2 <= crd.y * $signed({1'b0, w_s1});
			pz_s2 <= crd.z * $signed({1'b0, w_s1});
		end
		if (v_s2) begin
			acc_x_q <= acc_x_q + ACC_W'(px_s2);
			acc_y_q <= acc_y_q + ACC_W'(py_s2);
			acc_z_q <= acc_z_q + ACC_W'(pz_s2);
		end
		if (cmd.finish) begin
			out_q.surf_x <= sat_fn(acc_x_q);
			out_q.surf_y <= sat_fn(acc_y_q);
			out_q.surf_z <= sat_fn(acc_z_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/bezier_patch_point_evaluator_top.sv
// channel  dir  handshake             word
// in       in   in_valid/in_ready     in_data (load or evaluate)
// out      out  out_valid/out_ready   out_data (surface point)
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A load writes the point store and leaves the input ready. An evaluate runs M modulo
// steps on the offsets (up to 15), the Bernstein weight recurrence up to D = larger
// degree, and GR*GC = patch size store reads at one point per cycle, then drains.
// Reset sets config to 4, empties the point store (reads zero) and all handshake state.
// A waiting result holds out_data; the next item is taken meanwhile, and the
// finish step stalls only while the output register is still full.
module bezier_patch_point_evaluator_top #(
	parameter int MAX_GRID_DIM = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bpe_pkg::in_word_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpe_pkg::out_word_t        out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  bpe_pkg::cfg_idx_t         cfg_index,
	input  logic [bpe_pkg::CFG_W-1:0] cfg_data
);

	bpe_pkg::cmd_t    cmd;
	bpe_pkg::status_t st;

	assign cfg_ready = 1'b1;

	bpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	bpe_dp #(
		.MAX_GRID_DIM (MAX_GRID_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/bpe_checker.sv
`include "bezier_patch_point_evaluator_top_macros.svh"

module bpe_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input bpe_pkg::in_word_t         in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input bpe_pkg::out_word_t        out_data
);

	`BPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
	`BPE_ASSERT_NEXT(a_eval_busy, in_valid && in_ready && in_data.op == bpe_pkg::OP_EVAL, !in_ready, "evaluate did not block input")
	`BPE_ASSERT_NEXT(a_load_quick, in_valid && in_ready && in_data.op == bpe_pkg::OP_LOAD, in_ready, "load blocked input")
	`BPE_ASSERT_NOW(a_out_from_eval, $rose(out_valid), !$past(in_ready), "result without evaluate")

endmodule

bind bezier_patch_point_evaluator_top bpe_checker u_bpe_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int MAXD = 16;
	localparam int IDLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bpe_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bpe_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	bpe_pkg::cfg_idx_t cfg_index = bpe_pkg::CFG_GRID_ROWS;
	logic [bpe_pkg::CFG_W-1:0] cfg_data = '0;

	logic signed [31:0] px [MAXD*MAXD];
	logic signed [31:0] py [MAXD*MAXD];
	logic signed [31:0] pz [MAXD*MAXD];
	logic [4:0] grid_rows, grid_cols, group_rows, group_cols;
	bpe_pkg::out_word_t surface_q [$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	bezier_patch_point_evaluator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void bern_weights(input int deg, input logic [63:0] t,
			output logic [63:0] w [MAXD]);
		logic [63:0] s;
		logic [63:0] acc;
		s = 64'd65536 - t;
		for (int i = 0; i < MAXD; i++) w[i] = 64'd0;
		w[0] = 64'd1 << 30;
		for (int k = 1; k <= deg && k < MAXD; k++) begin
			for (int i = k; i >= 0; i--) begin
				acc = 64'd32768;
				if (i < k) acc += s * w[i];
				if (i > 0) acc += t * w[i-1];
				w[i] = acc >> 16;
			end
		end
	endfunction

	function automatic logic signed [31:0] round_sat(input logic signed [127:0] sum);
		logic signed [127:0] r;
		r = (sum + (128'sd1 <<< 29)) >>> 30;
		if (r > 128'sd2147483647) return 32'sh7fffffff;
		if (r < -128'sd2147483648) return 32'sh80000000;
		return r[31:0];
	endfunction

	function automatic void predict_surface(input bpe_pkg::in_word_t w);
		logic [63:0] wu [MAXD];
		logic [63:0] wv [MAXD];
		logic [63:0] t, pw;
		int nr, nc, gr, gc, row, col, a;
		logic signed [127:0] sx, sy, sz;
		bpe_pkg::out_word_t o;
		if (w.op == bpe_pkg::OP_LOAD) begin
			if (int'(w.point_index) < MAXD*MAXD) begin
				px[w.point_index] = w.point_x;
				py[w.point_index] = w.point_y;
				pz[w.point_index] = w.point_z;
			end
			return;
		end
		nr = (grid_rows == 5'd0) ? 1 : (int'(grid_rows) > MAXD ? MAXD : int'(grid_rows));
		nc = (grid_cols == 5'd0) ? 1 : (int'(grid_cols) > MAXD ? MAXD : int'(grid_cols));
		gr = (int'(group_rows) > 1 && int'(group_rows) <= nr) ? int'(group_rows) : nr;
		gc = (int'(group_cols) > 1 && int'(group_cols) <= nc) ? int'(group_cols) : nc;
		t = 64'((w.param_u > bpe_pkg::PAR_ONE) ? bpe_pkg::PAR_ONE : w.param_u);
		bern_weights(gc - 1, t, wu);
		t = 64'((w.param_v > bpe_pkg::PAR_ONE) ? bpe_pkg::PAR_ONE : w.param_v);
		bern_weights(gr - 1, t, wv);
		sx = 0; sy = 0; sz = 0;
		row = int'(w.row_offset) % nr;
		for (int m = 0; m < gr; m++) begin
			col = int'(w.col_offset) % nc;
			for (int n = 0; n < gc; n++) begin
				a = row * nc + col;
				pw = (wu[n] * wv[m] + (64'd1 << 29)) >> 30;
				sx += $signed(px[a]) * $signed({1'b0, pw});
				sy += $signed(py[a]) * $signed({1'b0, pw});
				sz += $signed(pz[a]) * $signed({1'b0, pw});
				col = (col + 1) % nc;
			end
			row = (row + 1) % nr;
		end
		o.surf_x = round_sat(sx);
		o.surf_y = round_sat(sy);
		o.surf_z = round_sat(sz);
		surface_q.push_back(o);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		bpe_pkg::out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (surface_q.size() == 0) begin
				report_mismatch("unexpected word", out_data.surf_x, 32'd0);
			end else begin
				e = surface_q.pop_front();
				if (out_data.surf_x !== e.surf_x)
					report_mismatch("surf_x", out_data.surf_x, e.surf_x);
				if (out_data.surf_y !== e.surf_y)
					report_mismatch("surf_y", out_data.surf_y, e.surf_y);
				if (out_data.surf_z !== e.surf_z)
					report_mismatch("surf_z", out_data.surf_z, e.surf_z);
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic send_word(input bpe_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_data = w;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_surface(w);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (surface_q.size() != 0) @(negedge clk);
		repeat (800) @(negedge clk);
	endtask

	task automatic write_reg(input bpe_pkg::cfg_idx_t idx, input logic [4:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bpe_pkg::CFG_GRID_ROWS:  grid_rows = val;
			bpe_pkg::CFG_GRID_COLS:  grid_cols = val;
			bpe_pkg::CFG_GROUP_ROWS: group_rows = val;
			default:                 group_cols = val;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_shape(input logic [4:0] r, input logic [4:0] c,
			input logic [4:0] gr, input logic [4:0] gc);
		drain();
		write_reg(bpe_pkg::CFG_GRID_ROWS, r);
		write_reg(bpe_pkg::CFG_GRID_COLS, c);
		write_reg(bpe_pkg::CFG_GROUP_ROWS, gr);
		write_reg(bpe_pkg::CFG_GROUP_COLS, gc);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_param();
		case ($urandom_range(7))
			0: return 17'd0;
			1: return bpe_pkg::PAR_ONE;
			2: return 17'h1ffff;
			3: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic bpe_pkg::in_word_t load_word(input int idx);
		bpe_pkg::in_word_t w;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = rnd[$bits(bpe_pkg::in_word_t)-1:0];
		w.op = bpe_pkg::OP_LOAD;
		w.point_index = 8'(idx);
		w.point_x = rand_coord();
		w.point_y = rand_coord();
		w.point_z = rand_coord();
		return w;
	endfunction

	function automatic bpe_pkg::in_word_t eval_word();
		bpe_pkg::in_word_t w;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = rnd[$bits(bpe_pkg::in_word_t)-1:0];
		w.op = bpe_pkg::OP_EVAL;
		w.param_u = rand_param();
		w.param_v = rand_param();
		return w;
	endfunction

	task automatic test_directed();
		bpe_pkg::in_word_t w;
		send_word(eval_word());
		for (int i = 0; i < 16; i++) begin
			w = load_word(i);
			w.point_x = (i & 1) ? 32'h7fffffff : 32'h80000000;
			send_word(w);
		end
		w = eval_word(); w.param_u = 17'd0; w.param_v = 17'd0; send_word(w);
		w = eval_word(); w.param_u = bpe_pkg::PAR_ONE; w.param_v = 17'h1ffff; send_word(w);
		w = eval_word(); w.row_offset = 4'd15; w.col_offset = 4'd15; send_word(w);
		w = eval_word(); w.param_u = 17'd32768; w.param_v = 17'd32768; send_word(w);
		set_shape(5'd0, 5'd31, 5'd1, 5'd0);
		send_word(eval_word());
		set_shape(5'd16, 5'd16, 5'd16, 5'd16);
		w = load_word(255); send_word(w);
		w = eval_word(); w.param_u = 17'd1; w.param_v = 17'd65535; send_word(w);
	endtask

	task automatic test_random(input int count, input int sidle, input int rstall);
		int r, c;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		r = $urandom_range(1, 4);
		c = $urandom_range(1, 4);
		if ($urandom_range(4) == 0) begin r = $urandom_range(0, 31); c = $urandom_range(0, 31); end
		set_shape(5'(r), 5'(c), 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(2) == 0) send_word(load_word($urandom_range(0, 255)));
			else send_word(eval_word());
		end
	endtask

	initial begin
		for (int i = 0; i < MAXD*MAXD; i++) begin px[i] = 0; py[i] = 0; pz[i] = 0; end
		grid_rows = 5'd4; grid_cols = 5'd4; group_rows = 5'd4; group_cols = 5'd4;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		for (int p = 0; p < 8; p++) test_random(60, 0, 0);
		for (int p = 0; p < 8; p++) test_random(60, 80, 0);
		for (int p = 0; p < 8; p++) test_random(60, 0, 80);
		for (int p = 0; p < 8; p++) test_random(60, 20, 20);
		drain();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
